/* rtl/core/lva_pkg.sv */
package lva_pkg;

  localparam int MAX_VOICES = 8;
  localparam int POS_W      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int ACT_W      = $clog2(MAX_VOICES + 1);
  localparam int ID_W       = 3;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int CFG_W      = 4;
  localparam int RESET_ACTIVE = (MAX_VOICES < 8) ? MAX_VOICES : 8;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    KIND_ON   = 2'd0,
    KIND_OFF  = 2'd1,
    KIND_FREE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [ID_W-1:0]   vid;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   voice;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic              note_sent;
  } res_t;

endpackage

/* rtl/core/lru_voice_allocator.sv */
// path: a request is registered in the front stage, queued, walked by the back end,
//   then its result is registered onto m_tvalid; a full queue or busy back end stalls it
// back end: takes a new command only when idle, after the last one is done; a note-off or
//   voice-free request walks the list one entry per cycle until it matches or passes the
//   last active voice; a held-off m_tready keeps it in emit while a result is unaccepted
// reset: synchronous; list set to ids 0..7, all slots cleared and 8 voices active at once
module lru_voice_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lva_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lva_pkg::IN_DATA_W-1:0]   s_tdata,   // note[6:0], velocity[13:7], voice_id[16:14]
  input  logic                            s_tuser,   // opcode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lva_pkg::OUT_DATA_W-1:0]  m_tdata,   // voice[2:0], out_note[9:3], out_velocity[16:10]
  output logic                            m_tuser    // note_sent
);
  import lva_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;
  res_t res;

  lva_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lva_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_cmd    (push_cmd),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_cmd   (pop_cmd)
  );

  lva_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_res     (res)
  );

  assign m_tdata = {{(OUT_DATA_W - ID_W - NOTE_W - VEL_W){1'b0}}, res.vel, res.note, res.voice};
  assign m_tuser = res.note_sent;

endmodule

/* rtl/core/lva_front.sv */
module lva_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lva_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                         s_tuser,
  output logic                         push_valid,
  input  logic                         push_ready,
  output lva_pkg::cmd_t                push_cmd
);
  import lva_pkg::*;

  logic f_valid;
  cmd_t f_cmd;
  cmd_t cmd_next;

  always_comb begin
    cmd_next.note = s_tdata[NOTE_W-1:0];
    cmd_next.vel  = s_tdata[NOTE_W+VEL_W-1:NOTE_W];
    cmd_next.vid  = s_tdata[NOTE_W+VEL_W+ID_W-1:NOTE_W+VEL_W];
    priority if (s_tuser) begin
      cmd_next.kind = KIND_FREE;
    end else if (cmd_next.vel == '0) begin
      cmd_next.kind = KIND_OFF;
    end else begin
      cmd_next.kind = KIND_ON;
    end
  end

  assign s_tready   = !f_valid || push_ready;
  assign push_valid = f_valid;
  assign push_cmd   = f_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (s_tready) begin
      f_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      f_cmd <= cmd_next;
    end
  end

endmodule

/* rtl/core/lva_queue.sv */
module lva_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lva_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output lva_pkg::cmd_t out_cmd
);
  import lva_pkg::*;

  cmd_t              ent [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign in_ready  = (count != QCNT_W'(QDEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = ent[rd_ptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= in_cmd;
    end
  end

endmodule

/* rtl/core/lva_back.sv */
module lva_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lva_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  lva_pkg::cmd_t                  pop_cmd,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output lva_pkg::res_t                  m_res
);
  import lva_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state;
  logic [POS_W-1:0]  idx;
  logic [ACT_W-1:0]  active;
  cmd_t              cur;
  res_t              pend;

  logic [ID_W-1:0]   order    [MAX_VOICES];
  logic [ID_W-1:0]   order_up [MAX_VOICES];
  logic [ID_W-1:0]   order_dn [MAX_VOICES];
  logic [NOTE_W-1:0] slot_note  [MAX_VOICES];
  logic              slot_valid [MAX_VOICES];
  logic [VEL_W-1:0]  slot_vel   [MAX_VOICES];

  logic [POS_W-1:0]  last_pos;
  logic [ID_W-1:0]   cur_id;
  logic [POS_W-1:0]  cur_slot;
  logic [POS_W-1:0]  front_slot;
  logic [POS_W-1:0]  vid_slot;
  logic              hit_off;
  logic              hit_free;
  logic [ACT_W-1:0]  cfg_sat;
  logic              out_free;

  // neighbor taps for the list moves, each at a fixed place
  for (genvar g = 0; g < MAX_VOICES; g++) begin : g_taps
    if (g < MAX_VOICES - 1) begin : g_up
      assign order_up[g] = order[g+1];
    end else begin : g_up_end
      assign order_up[g] = order[g];
    end
    if (g > 0) begin : g_dn
      assign order_dn[g] = order[g-1];
    end else begin : g_dn_end
      assign order_dn[g] = order[g];
    end
  end

  assign last_pos   = POS_W'(active - 1'b1);
  assign cur_id     = order[idx];
  assign cur_slot   = cur_id[POS_W-1:0];
  assign front_slot = order[0][POS_W-1:0];
  assign vid_slot   = cur.vid[POS_W-1:0];
  assign hit_off    = slot_valid[cur_slot] && (slot_note[cur_slot] == cur.note) &&
                      (slot_vel[cur_slot] != '0);
  assign hit_free   = (cur_id == cur.vid);
  assign pop_ready  = (state == ST_IDLE);
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    priority if (cfg_wdata == '0) begin
      cfg_sat = ACT_W'(1);
    end else if (int'(cfg_wdata) > MAX_VOICES) begin
      cfg_sat = ACT_W'(MAX_VOICES);
    end else begin
      cfg_sat = ACT_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      active <= rst ? ACT_W'(RESET_ACTIVE) : cfg_sat;
      for (int i = 0; i < MAX_VOICES; i++) begin
        order[i]      <= ID_W'(i);
        slot_note[i]  <= '0;
        slot_valid[i] <= 1'b0;
        slot_vel[i]   <= '0;
      end
    end else if (state == ST_WALK) begin
      unique case (cur.kind)
        KIND_ON: begin
          // front voice goes to the back of the active part
          for (int i = 0; i < MAX_VOICES; i++) begin
            if (POS_W'(i) < last_pos) begin
              order[i] <= order_up[i];
            end else if (POS_W'(i) == last_pos) begin
              order[i] <= order[0];
            end
          end
          slot_note[front_slot]  <= cur.note;
          slot_valid[front_slot] <= 1'b1;
          slot_vel[front_slot]   <= cur.vel;
        end
        KIND_OFF: begin
          if (hit_off) begin
            slot_vel[cur_slot] <= '0;
          end
        end
        KIND_FREE: begin
          if (hit_free) begin
            for (int i = 0; i < MAX_VOICES; i++) begin
              if (i == 0) begin
                order[i] <= cur.vid;
              end else if (POS_W'(i) <= idx) begin
                order[i] <= order_dn[i];
              end
            end
            slot_note[vid_slot]  <= '0;
            slot_valid[vid_slot] <= 1'b0;
            slot_vel[vid_slot]   <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          if (pop_valid) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          unique case (cur.kind)
            KIND_ON: begin
              state <= ST_EMIT;
            end
            KIND_OFF: begin
              if (hit_off) begin
                state <= ST_EMIT;
              end else if (idx == last_pos) begin
                state <= ST_IDLE;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            KIND_FREE: begin
              if (hit_free || idx == last_pos) begin
                state <= ST_IDLE;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop_valid) begin
      cur <= pop_cmd;
    end
    if (state == ST_WALK) begin
      if (cur.kind == KIND_ON) begin
        pend.voice     <= order[0];
        pend.note      <= cur.note;
        pend.vel       <= cur.vel;
        pend.note_sent <= 1'b1;
      end else begin
        pend.voice     <= cur_id;
        pend.note      <= '0;
        pend.vel       <= '0;
        pend.note_sent <= 1'b0;
      end
    end
    if (state == ST_EMIT && out_free) begin
      m_res <= pend;
    end
  end

`ifndef SYNTHESIS
  a_active_range: assert property (@(posedge clk) disable iff (rst)
    (active != '0) && (int'(active) <= MAX_VOICES))
    else $error("active voice count out of range");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (idx <= last_pos))
    else $error("list walk past last active voice");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_EMIT))
    else $error("result raised outside emit state");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |=> (state != ST_WALK) || $stable(cur))
    else $error("command changed during walk");
`endif

endmodule

/* tb/tb_lru_voice_allocator.sv */
module tb_lru_voice_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import lva_pkg::*;

  localparam bit OP_NOTE = 1'b0;
  localparam bit OP_FREE = 1'b1;
  localparam int SETTLE_CYCLES = 32;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;    // note[6:0], velocity[13:7], voice_id[16:14]
  logic                  s_tuser;    // opcode
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;    // voice[2:0], out_note[9:3], out_velocity[16:10]
  logic                  m_tuser;    // note_sent

  lru_voice_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // allocator image kept by the testbench
  logic [ID_W-1:0]   voice_order [MAX_VOICES];
  logic [NOTE_W-1:0] held_note   [MAX_VOICES];
  logic              note_live   [MAX_VOICES];
  logic [VEL_W-1:0]  held_vel    [MAX_VOICES];
  int                voices_in_use;

  res_t pending_results[$];

  bit calm;
  int errors;
  int requests_sent, results_seen, note_ons, note_offs, frees, cfg_writes;
  int stall_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void clear_voices(logic [CFG_W-1:0] value);
    int n;
    n = value;
    if (n < 1) n = 1;
    if (n > MAX_VOICES) n = MAX_VOICES;
    voices_in_use = n;
    for (int i = 0; i < MAX_VOICES; i++) begin
      voice_order[i] = ID_W'(i);
      held_note[i]   = '0;
      note_live[i]   = 1'b0;
      held_vel[i]    = '0;
    end
  endfunction

  function automatic void route_event(bit op, logic [NOTE_W-1:0] nt, logic [VEL_W-1:0] vl,
                                      logic [ID_W-1:0] vid);
    logic [ID_W-1:0] id;
    res_t r;
    int n;
    n = voices_in_use;
    if (op == OP_FREE) begin
      frees++;
      for (int i = 0; i < n; i++) begin
        if (voice_order[i] == vid) begin
          for (int j = i; j > 0; j--) voice_order[j] = voice_order[j-1];
          voice_order[0] = vid;
          held_note[vid] = '0;
          note_live[vid] = 1'b0;
          held_vel[vid]  = '0;
          break;
        end
      end
    end else if (vl == 0) begin
      note_offs++;
      for (int i = 0; i < n; i++) begin
        id = voice_order[i];
        if (note_live[id] && held_note[id] == nt && held_vel[id] != 0) begin
          held_vel[id] = '0;
          r.voice = id;
          r.note = '0;
          r.vel = '0;
          r.note_sent = 1'b0;
          pending_results = {pending_results, r};
          break;
        end
      end
    end else begin
      note_ons++;
      // front voice is stolen whatever it holds
      id = voice_order[0];
      for (int i = 0; i + 1 < n; i++) voice_order[i] = voice_order[i+1];
      voice_order[n-1] = id;
      held_note[id] = nt;
      note_live[id] = 1'b1;
      held_vel[id]  = vl;
      r.voice = id;
      r.note = nt;
      r.vel = vl;
      r.note_sent = 1'b1;
      pending_results = {pending_results, r};
    end
  endfunction

  // called at a falling edge, returns at a falling edge with s_tvalid still high
  task automatic send_request(bit op, logic [NOTE_W-1:0] nt, logic [VEL_W-1:0] vl,
                              logic [ID_W-1:0] vid);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, vid, vl, nt};
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    route_event(op, nt, vl, vid);
    @(negedge clk);
  endtask

  task automatic note_on(logic [NOTE_W-1:0] nt, logic [VEL_W-1:0] vl);
    send_request(OP_NOTE, nt, vl, '0);
  endtask

  task automatic note_off(logic [NOTE_W-1:0] nt);
    send_request(OP_NOTE, nt, '0, '0);
  endtask

  task automatic free_voice(logic [ID_W-1:0] vid);
    send_request(OP_FREE, '0, '0, vid);
  endtask

  // no result is pending and a note-off walk may still be running: let it finish
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_active(logic [CFG_W-1:0] value);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    clear_voices(value);
    cfg_writes++;
  endtask

  always @(negedge clk) begin
    if (rst || calm) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result voice=%0d note=%0d vel=%0d note_sent=%0d",
                   $realtime, m_tdata[2:0], m_tdata[9:3], m_tdata[16:10], m_tuser);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (m_tdata[2:0] !== want.voice || m_tdata[9:3] !== want.note ||
            m_tdata[16:10] !== want.vel || m_tuser !== want.note_sent ||
            m_tdata[OUT_DATA_W-1:17] !== '0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: mismatch expected voice=%0d note=%0d vel=%0d note_sent=%0d, %s",
                     $realtime, want.voice, want.note, want.vel, want.note_sent,
                     $sformatf("got voice=%0d note=%0d vel=%0d note_sent=%0d tdata=%h",
                               m_tdata[2:0], m_tdata[9:3], m_tdata[16:10], m_tuser, m_tdata));
        end
      end
    end
  end

  task automatic test_basic_allocation();
    note_on(7'd0, 7'd1);
    note_on(7'd127, 7'd127);
    note_on(7'd64, 7'd64);
    note_off(7'd127);
    note_off(7'd127);          // already released, no match
    note_off(7'd55);           // never played
    free_voice(3'd0);
    note_off(7'd0);            // freed voice no longer matches
    note_on(7'd60, 7'd100);    // freed voice sits at the front
    free_voice(3'd7);
    // more note-ons than voices: oldest ones get stolen
    for (int i = 0; i < 9; i++) note_on(7'(10 + i), 7'(1 + i));
    note_off(7'd10);           // stolen, gone
    note_off(7'd18);
    note_off(7'd64);
    send_request(OP_FREE, 7'h7f, 7'h7f, 3'd3);
    send_request(OP_NOTE, 7'h55, 7'h2a, 3'd7);
  endtask

  task automatic test_active_extremes();
    write_active(4'd0);        // saturates to one voice
    note_on(7'd30, 7'd90);
    note_on(7'd31, 7'd91);
    note_off(7'd30);
    note_off(7'd31);
    free_voice(3'd5);          // not among active voices
    free_voice(3'd0);
    note_on(7'd32, 7'd92);
    write_active(4'd15);       // saturates to all voices
    note_on(7'd40, 7'd1);
    free_voice(3'd7);
    note_off(7'd40);
    write_active(4'd1);
    free_voice(3'd1);
    note_on(7'd41, 7'd2);
    write_active(4'd8);
    free_voice(3'd7);
    note_on(7'd42, 7'd3);
  endtask

  task automatic test_random_traffic(logic [CFG_W-1:0] active, int count);
    int pick, n;
    logic [ID_W-1:0] vid;
    logic [NOTE_W-1:0] nt;
    write_active(active);
    for (int k = 0; k < count; k++) begin
      n = voices_in_use;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // narrow note pool now and then so several voices hold the same note
        nt = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(60, 67)) : 7'($urandom_range(0, 127));
        note_on(nt, 7'($urandom_range(1, 127)));
      end else if (pick < 70) begin
        vid = 3'($urandom_range(0, n - 1));
        nt = note_live[vid] ? held_note[vid] : 7'($urandom_range(0, 127));
        note_off(nt);
      end else if (pick < 80) begin
        free_voice(3'($urandom_range(0, n - 1)));
      end else begin
        send_request(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                     7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    m_tready   = 1'b1;
    calm       = 1'b0;
    stall_left = 0;
    errors     = 0;
    clear_voices(CFG_W'(RESET_ACTIVE));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_allocation();
    test_active_extremes();
    test_random_traffic(4'd8, 150);
    test_random_traffic(4'd1, 100);
    test_random_traffic(4'd3, 150);
    test_random_traffic(4'd15, 150);
    test_random_traffic(CFG_W'($urandom_range(0, 15)), 150);
    test_random_traffic(4'd0, 60);
    calm = 1'b1;
    test_random_traffic(4'd6, 150);

    settle_idle();
    if (pending_results.size() != 0) errors++;
    $display("%0d requests (%0d note-on, %0d note-off, %0d voice-free), %0d results checked",
             requests_sent, note_ons, note_offs, frees, results_seen);
    $display("%0d active-voice writes including 0, 1, 8 and 15; %0d errors",
             cfg_writes, errors);
    if (errors == 0) begin
      $display("tb_lru_voice_allocator passed");
    end else begin
      $display("tb_lru_voice_allocator failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("tb_lru_voice_allocator failed");
    $finish;
  end

endmodule
